// File: design/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg: shared types and constants of the barometric altitude estimator
// Field widths, register indexes and reset values, phase codes, the command
// and status records of the shared arithmetic unit, and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package bae_pkg;

   // field widths
   localparam int PRESSURE_W = 23;
   localparam int ALT_W      = 25;
   localparam int PHASE_W    = 2;
   localparam int COUNT_W    = 16;
   localparam int ALPHA_W    = 16;
   localparam int SCALE_W    = 24;

   // calibration sum: 65535 heights of 25 bits, signed
   localparam int SUM_W  = 41;
   // divider works on the sum magnitude
   localparam int DIVD_W = SUM_W - 1;
   // wide signed width used ahead of saturation
   localparam int SAT_W  = 42;
   // step counter of the shared unit (holds DIVD_W)
   localparam int STEP_W = 6;

   // default fixed-point layout
   localparam int PRESSURE_FRAC_BITS_DEF = 6;
   localparam int ALPHA_BITS_DEF         = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAL_SAMPLES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ALPHA = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_SCALE = 2'd2;

   localparam logic [COUNT_W-1:0] CAL_SAMPLES_RST  = 16'd100;
   localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = 16'd52429;
   localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RST = 24'd5452595;

   // phases
   localparam logic [PHASE_W-1:0] PHASE_GROUND = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_OFFSET = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_RUN    = 2'd2;

   // shared unit operations
   localparam logic ALU_OP_MUL = 1'b0;
   localparam logic ALU_OP_DIV = 1'b1;

   // output range
   localparam logic signed [SAT_W-1:0] ALT_MAX = 42'sd16777215;
   localparam logic signed [SAT_W-1:0] ALT_MIN = -42'sd16777216;

   typedef struct packed {
      logic                  action;
      logic [PRESSURE_W-1:0] pressure;
   } bae_req_type;

   typedef struct packed {
      logic signed [ALT_W-1:0] altitude_mm;
      logic [PHASE_W-1:0]      phase;
      logic                    altitude_valid;
   } bae_rsp_type;

   typedef struct packed {
      logic              start;
      logic              op;
      logic [STEP_W-1:0] steps;
   } bae_alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bae_alu_status_type;

   // clamp a wide signed value into the altitude range
   function automatic logic signed [ALT_W-1:0] sat_alt(input logic signed [SAT_W-1:0] v);
      logic signed [ALT_W-1:0] r;
      if (v > ALT_MAX) begin
         r = ALT_MAX[ALT_W-1:0];
      end else if (v < ALT_MIN) begin
         r = ALT_MIN[ALT_W-1:0];
      end else begin
         r = v[ALT_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/bae_alu.sv
// ----------------------------------------------------------------------------
// bae_alu: shared iterative arithmetic unit
// One adder/subtractor driven a step per cycle: shift-add multiply (one
// multiplier bit per step, optional preloaded accumulator) or restoring
// divide of a DIVD_W-bit dividend by a COUNT_W-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module bae_alu
   import bae_pkg::*;
#(
   parameter int ACC_W = 64,
   parameter int OPB_W = DIVD_W
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bae_alu_cmd_type    cmd,
   input  wire logic [ACC_W-1:0]   opa_init,
   input  wire logic [OPB_W-1:0]   opb_init,
   input  wire logic [ACC_W-1:0]   acc_init,
   output bae_alu_status_type      status,
   output logic [ACC_W-1:0]        acc,
   output logic [OPB_W-1:0]        opb
);

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  opa_ff, opa_in;
   logic [OPB_W-1:0]  opb_ff, opb_in;
   logic              op_ff, op_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] count_ff, count_in;

   logic [COUNT_W:0]  div_sh;
   logic [ACC_W-1:0]  add_x, add_y, add_sum;
   logic              add_sub;
   logic              qbit;

   // shared adder: accumulate for multiply, trial subtract for divide
   assign div_sh  = {acc_ff[COUNT_W-1:0], opb_ff[OPB_W-1]};
   assign add_sub = (op_ff == ALU_OP_DIV);
   assign add_x   = add_sub ? ACC_W'(div_sh) : acc_ff;
   assign add_y   = add_sub ? ~opa_ff : opa_ff;
   assign add_sum = add_x + add_y + ACC_W'(add_sub);
   assign qbit    = ~add_sum[ACC_W-1];

   // step sequencing
   always_comb begin
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      op_in    = op_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      if (cmd.start) begin
         acc_in   = acc_init;
         opa_in   = opa_init;
         opb_in   = opb_init;
         op_in    = cmd.op;
         busy_in  = 1'b1;
         count_in = cmd.steps;
      end else if (busy_ff) begin
         if (op_ff == ALU_OP_DIV) begin
            acc_in = qbit ? add_sum : ACC_W'(div_sh);
            opb_in = {opb_ff[OPB_W-2:0], qbit};
         end else begin
            if (opb_ff[0]) begin
               acc_in = add_sum;
            end
            opa_in = {opa_ff[ACC_W-2:0], 1'b0};
            opb_in = {1'b0, opb_ff[OPB_W-1:1]};
         end
         count_in = count_ff - STEP_W'(1);
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      op_ff  <= op_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign acc         = acc_ff;
   assign opb         = opb_ff;

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("bae_alu: start while busy");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("bae_alu: done and busy together");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("bae_alu: done without a run");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff && (op_ff == ALU_OP_DIV) |-> acc_ff < opa_ff)
      else $error("bae_alu: remainder not below divisor");

endmodule

`default_nettype wire

// File: design/barometric_altitude_estimator.sv
// ----------------------------------------------------------------------------
// barometric_altitude_estimator: relative altitude from pressure samples
// Ground and offset calibration by averaging, then low-pass filtered
// altitude in millimetres, all on one shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
// Usage: one pressure sample (or a restart command) per req_ transfer, one
// result per item on the rsp_ channel. The csr_ channel writes the
// calibration sample count, filter_alpha and height_scale; it is always
// ready, and it is to be written while the block is idle; the block
// itself does not enforce this. Steps per item:
//   restart or ground-phase sample: dispatch, then output
//   ground phase end: a divide of the pressure sum
//   offset-phase sample: a height multiply; phase end adds a divide
//   running sample: two filter multiplies, then the height multiply
// The work is done by the shift-add multiplier (one multiplier bit per cycle)
// and the restoring divider (one quotient bit per cycle) sharing one adder.
// One item is in work at a time; req_ready is high only between items.
// A finished result waits in the rsp_ output register, and the next item is
// taken meanwhile; a new result waits until the previous one is taken.
// Reset restores the register defaults, clears all calibration and filter
// state and starts in the ground phase with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_altitude_estimator
   import bae_pkg::*;
#(
   parameter int PRESSURE_FRAC_BITS = PRESSURE_FRAC_BITS_DEF,
   parameter int ALPHA_BITS         = ALPHA_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire bae_req_type            req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output bae_rsp_type                 rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // filter state width, alpha width, shared unit width, height shift
   localparam int FILT_W = PRESSURE_W + ALPHA_BITS;
   localparam int AW     = ALPHA_BITS + 1;
   localparam int ACC_W  = FILT_W + SCALE_W + 1;
   localparam int SH     = PRESSURE_FRAC_BITS + ALPHA_BITS + 16;
   localparam int QW     = ACC_W - SH;
   localparam logic [AW-1:0] ALPHA_ONE = {1'b1, {ALPHA_BITS{1'b0}}};

   // sequencer states
   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DISPATCH   = 4'd1;
   localparam logic [3:0] S_GROUND_DIV = 4'd2;
   localparam logic [3:0] S_OFS_MUL    = 4'd3;
   localparam logic [3:0] S_OFS_DIV    = 4'd4;
   localparam logic [3:0] S_FLT_MUL1   = 4'd5;
   localparam logic [3:0] S_FLT_MUL2   = 4'd6;
   localparam logic [3:0] S_ALT_MUL    = 4'd7;
   localparam logic [3:0] S_OUT        = 4'd8;

   logic [3:0]               state_ff, state_in;
   bae_req_type              req_ff, req_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [PRESSURE_W-1:0]    ground_ff, ground_in;
   logic signed [ALT_W-1:0]  offset_ff, offset_in;
   logic [FILT_W-1:0]        filt_ff, filt_in;
   logic                     neg_ff, neg_in;
   logic                     above_ff, above_in;
   bae_rsp_type              res_ff, res_in;
   bae_rsp_type              rsp_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_load;

   logic [COUNT_W-1:0]       cal_samples_ff;
   logic [ALPHA_W-1:0]       filter_alpha_ff;
   logic [SCALE_W-1:0]       height_scale_ff;

   bae_alu_cmd_type          alu_cmd;
   bae_alu_status_type       alu_status;
   logic [ACC_W-1:0]         alu_opa, alu_acc_init, alu_acc;
   logic [DIVD_W-1:0]        alu_opb, alu_quot;
   logic [DIVD_W-1:0]        alu_opb_out;

   logic [COUNT_W-1:0]       n_eff, cnt_inc;
   logic                     cnt_end;
   logic [AW-1:0]            a_eff;
   logic [FILT_W-1:0]        ground_ext, hsrc, hmag;
   logic                     above;
   logic [QW-1:0]            hq;
   logic signed [SAT_W-1:0]  hq_wide;
   logic signed [ALT_W-1:0]  h_sat;
   logic signed [SUM_W-1:0]  sum_p, sum_h, sum_h_mag;
   logic signed [SAT_W-1:0]  alt_diff, ofs_wide;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_samples_ff  <= CAL_SAMPLES_RST;
         filter_alpha_ff <= FILTER_ALPHA_RST;
         height_scale_ff <= HEIGHT_SCALE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAL_SAMPLES:  cal_samples_ff  <= csr_data[COUNT_W-1:0];
            CSR_FILTER_ALPHA: filter_alpha_ff <= csr_data[ALPHA_W-1:0];
            CSR_HEIGHT_SCALE: height_scale_ff <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // sample counting, zero count acts as one
   assign n_eff   = (cal_samples_ff == '0) ? COUNT_W'(1) : cal_samples_ff;
   assign cnt_inc = count_ff + COUNT_W'(1);
   assign cnt_end = (cnt_inc >= n_eff);

   // filter weight clamped to one
   assign a_eff = (32'(filter_alpha_ff) > 32'(ALPHA_ONE)) ? ALPHA_ONE : AW'(filter_alpha_ff);

   // pressure difference from ground at filter resolution
   assign ground_ext = {ground_ff, {ALPHA_BITS{1'b0}}};
   assign hsrc  = (state_ff == S_DISPATCH) ? {req_ff.pressure, {ALPHA_BITS{1'b0}}}
                                           : alu_acc[FILT_W-1:0];
   assign above = (hsrc > ground_ext);
   assign hmag  = above ? (hsrc - ground_ext) : (ground_ext - hsrc);

   // height from the product, negated above ground, saturated
   assign hq      = alu_acc[ACC_W-1:SH];
   assign hq_wide = $signed(SAT_W'(hq));
   assign h_sat   = sat_alt(above_ff ? -hq_wide : hq_wide);

   // calibration sums
   assign sum_p     = sum_ff + $signed(SUM_W'(req_ff.pressure));
   assign sum_h     = sum_ff + {{(SUM_W-ALT_W){h_sat[ALT_W-1]}}, h_sat};
   assign sum_h_mag = sum_h[SUM_W-1] ? -sum_h : sum_h;

   // offset average with sign restored, altitude against offset
   assign alu_quot = alu_opb_out;
   assign ofs_wide = neg_ff ? -$signed(SAT_W'(alu_quot)) : $signed(SAT_W'(alu_quot));
   assign alt_diff = {{(SAT_W-ALT_W){h_sat[ALT_W-1]}}, h_sat}
                   - {{(SAT_W-ALT_W){offset_ff[ALT_W-1]}}, offset_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      ground_in    = ground_ff;
      offset_in    = offset_ff;
      filt_in      = filt_ff;
      neg_in       = neg_ff;
      above_in     = above_ff;
      res_in       = res_ff;
      rsp_load     = 1'b0;
      alu_cmd      = '0;
      alu_opa      = '0;
      alu_opb      = '0;
      alu_acc_init = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_in.altitude_mm    = '0;
            res_in.altitude_valid = 1'b0;
            if (req_ff.action) begin
               phase_in     = PHASE_GROUND;
               count_in     = '0;
               sum_in       = '0;
               res_in.phase = PHASE_GROUND;
               state_in     = S_OUT;
            end else begin
               case (phase_ff)
                  PHASE_GROUND: begin
                     if (cnt_end) begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = ALU_OP_DIV;
                        alu_cmd.steps = STEP_W'(DIVD_W);
                        alu_opa       = ACC_W'(n_eff);
                        alu_opb       = sum_p[DIVD_W-1:0];
                        count_in      = '0;
                        sum_in        = '0;
                        state_in      = S_GROUND_DIV;
                     end else begin
                        sum_in       = sum_p;
                        count_in     = cnt_inc;
                        res_in.phase = PHASE_GROUND;
                        state_in     = S_OUT;
                     end
                  end
                  PHASE_OFFSET: begin
                     alu_cmd.start = 1'b1;
                     alu_cmd.op    = ALU_OP_MUL;
                     alu_cmd.steps = STEP_W'(SCALE_W);
                     alu_opa       = ACC_W'(hmag);
                     alu_opb       = DIVD_W'(height_scale_ff);
                     above_in      = above;
                     state_in      = S_OFS_MUL;
                  end
                  default: begin
                     alu_cmd.start = 1'b1;
                     alu_cmd.op    = ALU_OP_MUL;
                     alu_cmd.steps = STEP_W'(AW);
                     alu_opa       = ACC_W'(filt_ff);
                     alu_opb       = DIVD_W'(a_eff);
                     state_in      = S_FLT_MUL1;
                  end
               endcase
            end
         end
         S_GROUND_DIV: begin
            if (alu_status.done) begin
               ground_in    = alu_quot[PRESSURE_W-1:0];
               phase_in     = PHASE_OFFSET;
               res_in.phase = PHASE_OFFSET;
               state_in     = S_OUT;
            end
         end
         S_OFS_MUL: begin
            if (alu_status.done) begin
               if (cnt_end) begin
                  alu_cmd.start = 1'b1;
                  alu_cmd.op    = ALU_OP_DIV;
                  alu_cmd.steps = STEP_W'(DIVD_W);
                  alu_opa       = ACC_W'(n_eff);
                  alu_opb       = sum_h_mag[DIVD_W-1:0];
                  neg_in        = sum_h[SUM_W-1];
                  count_in      = '0;
                  sum_in        = '0;
                  state_in      = S_OFS_DIV;
               end else begin
                  sum_in       = sum_h;
                  count_in     = cnt_inc;
                  res_in.phase = PHASE_OFFSET;
                  state_in     = S_OUT;
               end
            end
         end
         S_OFS_DIV: begin
            if (alu_status.done) begin
               offset_in    = sat_alt(ofs_wide);
               phase_in     = PHASE_RUN;
               res_in.phase = PHASE_RUN;
               state_in     = S_OUT;
            end
         end
         S_FLT_MUL1: begin
            // second pass adds the new-sample share onto the scaled old value
            if (alu_status.done) begin
               alu_cmd.start = 1'b1;
               alu_cmd.op    = ALU_OP_MUL;
               alu_cmd.steps = STEP_W'(AW);
               alu_acc_init  = alu_acc >> ALPHA_BITS;
               alu_opa       = ACC_W'(req_ff.pressure);
               alu_opb       = DIVD_W'(ALPHA_ONE - a_eff);
               state_in      = S_FLT_MUL2;
            end
         end
         S_FLT_MUL2: begin
            if (alu_status.done) begin
               filt_in       = alu_acc[FILT_W-1:0];
               alu_cmd.start = 1'b1;
               alu_cmd.op    = ALU_OP_MUL;
               alu_cmd.steps = STEP_W'(SCALE_W);
               alu_opa       = ACC_W'(hmag);
               alu_opb       = DIVD_W'(height_scale_ff);
               above_in      = above;
               state_in      = S_ALT_MUL;
            end
         end
         S_ALT_MUL: begin
            if (alu_status.done) begin
               res_in.altitude_mm    = sat_alt(alt_diff);
               res_in.phase          = PHASE_RUN;
               res_in.altitude_valid = 1'b1;
               state_in              = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register, refilled on the cycle its transfer completes
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      neg_ff   <= neg_in;
      above_ff <= above_in;
      res_ff   <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PHASE_GROUND;
         count_ff     <= '0;
         sum_ff       <= '0;
         ground_ff    <= '0;
         offset_ff    <= '0;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ground_ff    <= ground_in;
         offset_ff    <= offset_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // shared multiply / divide unit
   bae_alu #(
      .ACC_W (ACC_W),
      .OPB_W (DIVD_W)
   ) u_alu (
      .clock    (clock),
      .reset    (reset),
      .cmd      (alu_cmd),
      .opa_init (alu_opa),
      .opb_init (alu_opb),
      .acc_init (alu_acc_init),
      .status   (alu_status),
      .acc      (alu_acc),
      .opb      (alu_opb_out)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_valid_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.altitude_valid |-> rsp_payload.phase == PHASE_RUN)
      else $error("altitude marked valid outside running phase");
   a_zero_calib: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.altitude_valid |-> rsp_payload.altitude_mm == '0)
      else $error("nonzero altitude while calibrating");
   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_RUN |-> count_ff == '0 && sum_ff == '0)
      else $error("calibration state left over in running phase");
   a_alu_engaged: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GROUND_DIV || state_ff == S_OFS_MUL || state_ff == S_OFS_DIV ||
       state_ff == S_FLT_MUL1 || state_ff == S_FLT_MUL2 || state_ff == S_ALT_MUL)
      |-> alu_status.busy || alu_status.done)
      else $error("sequencer waits on an idle arithmetic unit");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the barometric altitude estimator
// Streams pressure samples and restart commands through the req_ channel
// under random stalls on both sides. A built-in fixed-point tracker of the
// calibration phases and the low-pass filter predicts every rsp_ transfer,
// which is compared field by field in order. Register settings change only
// while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bae_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned CALM_FROM     = 30_000;
   localparam int unsigned CALM_TO       = 55_000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_CYCLES  = 100;
   localparam int unsigned ITEM_TARGET   = 1750;
   localparam int unsigned SHOWN_FAULTS  = 10;

   localparam logic ACT_SAMPLE  = 1'b0;
   localparam logic ACT_RESTART = 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int FRAC_SHIFT = PRESSURE_FRAC_BITS_DEF + ALPHA_BITS_DEF + 16;
   localparam longint unsigned ALPHA_ONE = 64'd1 << ALPHA_BITS_DEF;
   localparam logic [PRESSURE_W-1:0] P_MAX = '1;
   localparam int unsigned P_TOP = 8388607;
   localparam logic [PRESSURE_W-1:0] P_SEA = 23'd6484800;
   localparam longint ALT_TOP    = 16777215;
   localparam longint ALT_BOTTOM = -16777216;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   bae_req_type            req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   bae_rsp_type            rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   bae_req_type sample_backlog[$];
   bae_rsp_type altitude_due[$];
   int unsigned cycle_count = 0;
   int unsigned fault_count = 0;
   int unsigned items_made = 0;

   // tracked register settings
   logic [COUNT_W-1:0] cfg_count = CAL_SAMPLES_RST;
   logic [ALPHA_W-1:0] cfg_alpha = FILTER_ALPHA_RST;
   logic [SCALE_W-1:0] cfg_scale = HEIGHT_SCALE_RST;

   // tracked calibration and filter state
   logic [PHASE_W-1:0]    phase_now = PHASE_GROUND;
   logic [COUNT_W-1:0]    taken = '0;
   longint                cal_sum = 0;
   logic [PRESSURE_W-1:0] ground_ref = '0;
   longint                offset_mm = 0;
   longint unsigned       lowpass_y = 0;

   barometric_altitude_estimator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #4ns clock = ~clock;

   // random stall, none inside the calm window
   function automatic logic lull();
      if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
         return 1'b0;
      end
      return $urandom_range(99) < 8;
   endfunction

   function automatic longint clamp_alt(input longint v);
      if (v > ALT_TOP) begin
         return ALT_TOP;
      end
      if (v < ALT_BOTTOM) begin
         return ALT_BOTTOM;
      end
      return v;
   endfunction

   // height above ground of a pressure held at filter resolution, toward zero
   function automatic longint height_mm(input longint unsigned y);
      longint unsigned g, mag, hi, lo, q;
      logic above;
      g = 64'(ground_ref) << ALPHA_BITS_DEF;
      above = y > g;
      mag = above ? y - g : g - y;
      hi = (mag >> 24) * cfg_scale;
      lo = (mag & 64'hFF_FFFF) * cfg_scale;
      q = (hi + (lo >> 24)) >> (FRAC_SHIFT - 24);
      return clamp_alt(above ? -longint'(q) : longint'(q));
   endfunction

   // advance the tracked state by one accepted entry, return the due result
   function automatic bae_rsp_type track_altitude(input bae_req_type entry);
      longint unsigned n, a, p;
      longint alt;
      bae_rsp_type res;
      n = (cfg_count == 0) ? 64'd1 : 64'(cfg_count);
      p = 64'(entry.pressure);
      alt = 0;
      res = '0;
      if (entry.action == ACT_RESTART) begin
         phase_now = PHASE_GROUND;
         taken = '0;
         cal_sum = 0;
      end else if (phase_now == PHASE_GROUND) begin
         cal_sum += longint'(p);
         taken = taken + 1'b1;
         if (64'(taken) >= n) begin
            ground_ref = PRESSURE_W'(64'(cal_sum) / n);
            cal_sum = 0;
            taken = '0;
            phase_now = PHASE_OFFSET;
         end
      end else if (phase_now == PHASE_OFFSET) begin
         cal_sum += height_mm(p << ALPHA_BITS_DEF);
         taken = taken + 1'b1;
         if (64'(taken) >= n) begin
            offset_mm = clamp_alt(cal_sum / longint'(n));
            cal_sum = 0;
            taken = '0;
            phase_now = PHASE_RUN;
         end
      end else begin
         a = (64'(cfg_alpha) > ALPHA_ONE) ? ALPHA_ONE : 64'(cfg_alpha);
         lowpass_y = ((a * lowpass_y) >> ALPHA_BITS_DEF) + (ALPHA_ONE - a) * p;
         alt = clamp_alt(height_mm(lowpass_y) - offset_mm);
         res.altitude_valid = 1'b1;
      end
      res.altitude_mm = ALT_W'(alt);
      res.phase = phase_now;
      return res;
   endfunction

   task automatic log_fault(input string what, input bae_rsp_type want,
                            input bae_rsp_type got);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS) begin
         $display("%0t %s: expected alt %0d phase %0d valid %0b, got alt %0d phase %0d valid %0b",
                  $realtime, what, $signed(want.altitude_mm), want.phase,
                  want.altitude_valid, $signed(got.altitude_mm), got.phase,
                  got.altitude_valid);
      end
   endtask

   // request driver, predicts each transfer as it happens
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            altitude_due.push_back(track_altitude(req_payload));
         end
         if (!req_valid || req_ready) begin
            if (sample_backlog.size() != 0 && !lull()) begin
               req_valid <= 1'b1;
               req_payload <= sample_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      bae_rsp_type want;
      rsp_ready <= !lull();
      if (!reset && rsp_valid && rsp_ready) begin
         if (altitude_due.size() == 0) begin
            log_fault("result with none pending", '0, rsp_payload);
         end else begin
            want = altitude_due.pop_front();
            if (rsp_payload.altitude_mm !== want.altitude_mm ||
                rsp_payload.phase !== want.phase ||
                rsp_payload.altitude_valid !== want.altitude_valid) begin
               log_fault("result mismatch", want, rsp_payload);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send(input logic action, input logic [PRESSURE_W-1:0] pressure);
      bae_req_type entry;
      entry.action = action;
      entry.pressure = pressure;
      sample_backlog.push_back(entry);
      items_made++;
   endtask

   // wait until every queued sample is through and every result is in
   task automatic settle();
      while (sample_backlog.size() != 0 || req_valid || altitude_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only on a drained block
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      settle();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CAL_SAMPLES:  cfg_count = value[COUNT_W-1:0];
         CSR_FILTER_ALPHA: cfg_alpha = value[ALPHA_W-1:0];
         CSR_HEIGHT_SCALE: cfg_scale = value[SCALE_W-1:0];
         default: ;
      endcase
   endtask

   initial begin
      int unsigned base, span;
      int level;
      logic [COUNT_W-1:0] count;
      logic [ALPHA_W-1:0] alpha;
      logic [SCALE_W-1:0] scale;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // calibrate on the pressure extremes, upper data bits dropped
      write_reg(CSR_CAL_SAMPLES, 24'hFF0002);
      send(ACT_SAMPLE, '0);
      send(ACT_SAMPLE, P_MAX);
      send(ACT_SAMPLE, P_MAX);
      send(ACT_SAMPLE, '0);
      send(ACT_SAMPLE, P_MAX);
      send(ACT_SAMPLE, '0);
      send(ACT_SAMPLE, P_SEA);
      // restart ignores its pressure, filter state is kept
      send(ACT_RESTART, P_MAX);
      send(ACT_SAMPLE, P_SEA);
      // largest count, then lowered below the samples already taken
      write_reg(CSR_CAL_SAMPLES, 24'h00FFFF);
      send(ACT_SAMPLE, 23'd100);
      send(ACT_SAMPLE, P_MAX - 1'b1);
      write_reg(CSR_CAL_SAMPLES, 24'd1);
      send(ACT_SAMPLE, P_SEA);
      // zero count acts as one
      write_reg(CSR_CAL_SAMPLES, 24'd0);
      send(ACT_SAMPLE, 23'd6484000);
      // no filtering, then full scale to hit both saturation limits
      write_reg(CSR_FILTER_ALPHA, 24'd0);
      send(ACT_SAMPLE, P_MAX);
      send(ACT_SAMPLE, '0);
      write_reg(CSR_HEIGHT_SCALE, 24'hFFFFFF);
      send(ACT_SAMPLE, '0);
      send(ACT_SAMPLE, P_MAX);
      write_reg(CSR_FILTER_ALPHA, 24'hFFFFFF);
      send(ACT_SAMPLE, 23'd12345);
      // write to the unused index changes nothing
      write_reg(CSR_UNUSED, 24'd1);
      send(ACT_SAMPLE, P_SEA);
      write_reg(CSR_HEIGHT_SCALE, 24'd0);
      send(ACT_SAMPLE, P_MAX);
      send(ACT_RESTART, '0);
      send(ACT_SAMPLE, P_SEA);
      send(ACT_SAMPLE, 23'd6484900);

      // random rounds: new settings, mostly short calibrations, noisy samples
      while (items_made < ITEM_TARGET) begin
         case ($urandom_range(7))
            0: count = 16'($urandom_range(0, 64));
            default: count = 16'($urandom_range(1, 6));
         endcase
         case ($urandom_range(5))
            0: alpha = '0;
            1: alpha = '1;
            2: alpha = 16'($urandom);
            default: alpha = FILTER_ALPHA_RST;
         endcase
         case ($urandom_range(5))
            0: scale = '0;
            1: scale = '1;
            2: scale = 24'($urandom);
            default: scale = HEIGHT_SCALE_RST;
         endcase
         write_reg(CSR_CAL_SAMPLES, {8'($urandom), count});
         write_reg(CSR_FILTER_ALPHA, {8'($urandom), alpha});
         write_reg(CSR_HEIGHT_SCALE, scale);
         if ($urandom_range(7) == 0) begin
            write_reg(CSR_UNUSED, 24'($urandom));
         end
         if ($urandom_range(1) == 1) begin
            send(ACT_RESTART, 23'($urandom));
         end
         base = $urandom_range(0, P_TOP);
         span = $urandom_range(20, 120);
         for (int k = 0; k < span; k++) begin
            if ($urandom_range(99) < 3) begin
               send(ACT_RESTART, 23'($urandom));
            end else if ($urandom_range(99) < 20) begin
               send(ACT_SAMPLE, 23'($urandom_range(0, P_TOP)));
            end else begin
               level = int'(base) + int'($urandom_range(0, 4000)) - 2000;
               if (level < 0) begin
                  level = 0;
               end else if (level > int'(P_TOP)) begin
                  level = int'(P_TOP);
               end
               send(ACT_SAMPLE, 23'(level));
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (altitude_due.size() != 0) begin
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
design/bae_pkg.sv
design/bae_alu.sv
design/barometric_altitude_estimator.sv
bench/tb_top.sv
